### rtl/core/fir16_pkg.sv
// fir16_pkg: shared constants, register indexes and FSM states for the
// 16-bit direct-form FIR filter. No dependencies; used by fir_filter_16bit.
package fir16_pkg;

  // Filter geometry
  localparam int MAX_TAPS = 1024;
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 10;
  localparam int TAPS_W     = 11;
  localparam int SHIFT_W    = 5;
  localparam int ACC_W      = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register reset values
  localparam logic [TAPS_W-1:0]  TAPS_RESET  = 11'd1024;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

  // Register word index (byte address bit 2)
  typedef enum logic [0:0] {
    REG_TAPS  = 1'b0,
    REG_SHIFT = 1'b1
  } reg_index_t;

  // Item action codes
  typedef enum logic [0:0] {
    ACT_SAMPLE = 1'b0,
    ACT_LOAD   = 1'b1
  } action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PUSH,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } fsm_state_t;

endpackage

### rtl/core/fir16_ram.sv
// fir16_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies; used for the delay line and the coefficient store.
module fir16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/fir_filter_16bit.sv
// fir_filter_16bit: top level of the 16-bit direct-form FIR filter.
// Depends on fir16_pkg and fir16_ram (delay line and coefficient store).
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, tap_index and value.
//   A load item (action 1) writes value into coefficient tap_index (ignored
//   when tap_index is past the last tap) and gives no result. A sample item
//   (action 0) enters the delay line as the newest sample and gives one
//   filtered_sample on the output channel.
//   One multiply-accumulate unit walks the taps, one tap per cycle, through
//   a registered RAM read, a product register and the accumulator. With n
//   the tap count in use (taps_in_use clamped to 1 .. 1024), a sample item
//   walks n taps before its sum goes to the output register; the next item
//   is accepted only after that, as in_ready is high only while the sequencer
//   is idle.
//   The result sits in an output register: in_ready comes back as soon as it
//   is loaded, so a stalled receiver holds only the next sample item, which
//   waits at the end of its sum until the register is free.
//   Configuration is an APB port: taps_in_use at 0x0, output_shift at 0x4.
//   Write registers only while the filter is idle.
//   Reset (synchronous) sets taps_in_use to 1024, output_shift to 15 and
//   empties the delay line: a fill count marks history older than reset as
//   zero, so no clearing pass runs. Coefficients must be loaded before use.
module fir_filter_16bit (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic [fir16_pkg::INDEX_W-1:0]         tap_index,
  input  logic signed [fir16_pkg::SAMPLE_W-1:0] value,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fir16_pkg::SAMPLE_W-1:0] filtered_sample,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fir16_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fir16_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fir16_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int AW = fir16_pkg::ADDR_W;
  localparam int CW = fir16_pkg::CNT_W;
  localparam int SW = fir16_pkg::SAMPLE_W;
  localparam int XW = fir16_pkg::ACC_W;

  localparam logic [AW-1:0] LAST_POS = AW'(fir16_pkg::MAX_TAPS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(fir16_pkg::MAX_TAPS);

  fir16_pkg::fsm_state_t state, state_next;

  // configuration registers
  logic [fir16_pkg::TAPS_W-1:0]  taps_in_use;
  logic [fir16_pkg::SHIFT_W-1:0] output_shift;

  // captured item
  logic [fir16_pkg::INDEX_W-1:0] item_index;
  logic [SW-1:0]                 item_value;

  // delay line bookkeeping and tap walk
  logic [AW-1:0] newest_pos;
  logic [AW-1:0] newest_dec;
  logic [CW-1:0] fill;
  logic [CW-1:0] k;
  logic [AW-1:0] pos;
  logic [CW-1:0] n_eff;
  logic          idx_ok;

  // MAC pipeline
  logic                 rd_valid;
  logic                 rd_zero;
  logic                 prod_valid;
  logic signed [XW-1:0] prod;
  logic signed [XW-1:0] acc;
  logic signed [SW-1:0] coef_q;
  logic signed [SW-1:0] dly_q;
  logic signed [XW-1:0] shifted;

  // sequencer controls
  logic coef_we;
  logic dly_we;
  logic issue;
  logic out_load;
  logic cfg_we;

  // APB port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use  <= fir16_pkg::TAPS_RESET;
      output_shift <= fir16_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (fir16_pkg::reg_index_t'(paddr[2]))
        fir16_pkg::REG_TAPS:  taps_in_use  <= pwdata[fir16_pkg::TAPS_W-1:0];
        fir16_pkg::REG_SHIFT: output_shift <= pwdata[fir16_pkg::SHIFT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (fir16_pkg::reg_index_t'(paddr[2]))
      fir16_pkg::REG_TAPS:  prdata = fir16_pkg::APB_DATA_W'(taps_in_use);
      fir16_pkg::REG_SHIFT: prdata = fir16_pkg::APB_DATA_W'(output_shift);
    endcase
  end

  // effective tap count: zero means one, clamp at the delay line length
  always_comb begin
    int t;
    t = int'(taps_in_use);
    if (t < 1) begin
      t = 1;
    end
    if (t > fir16_pkg::MAX_TAPS) begin
      t = fir16_pkg::MAX_TAPS;
    end
    n_eff = CW'(t);
  end

  assign newest_dec = (newest_pos == '0) ? LAST_POS : newest_pos - AW'(1);
  assign idx_ok     = int'(item_index) < fir16_pkg::MAX_TAPS;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fir16_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    coef_we    = 1'b0;
    dly_we     = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fir16_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (action == fir16_pkg::ACT_LOAD) ? fir16_pkg::ST_LOAD
                                                      : fir16_pkg::ST_PUSH;
        end
      end
      fir16_pkg::ST_LOAD: begin
        coef_we    = idx_ok;
        state_next = fir16_pkg::ST_IDLE;
      end
      fir16_pkg::ST_PUSH: begin
        dly_we     = 1'b1;
        state_next = fir16_pkg::ST_MAC;
      end
      fir16_pkg::ST_MAC: begin
        issue = 1'b1;
        if (k == n_eff - CW'(1)) begin
          state_next = fir16_pkg::ST_DRAIN;
        end
      end
      fir16_pkg::ST_DRAIN: begin
        if (!rd_valid && !prod_valid) begin
          state_next = fir16_pkg::ST_DONE;
        end
      end
      fir16_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = fir16_pkg::ST_IDLE;
        end
      end
      default: state_next = fir16_pkg::ST_IDLE;
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_index  <= tap_index;
      item_value  <= value;
    end
  end

  // delay line pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_pos <= '0;
      fill       <= '0;
    end else if (dly_we) begin
      newest_pos <= newest_dec;
      if (fill != FULL_CNT) begin
        fill <= fill + CW'(1);
      end
    end
  end

  // tap walk: k over coefficients, pos over the delay line, oldest last
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      pos <= '0;
    end else if (dly_we) begin
      k   <= '0;
      pos <= newest_dec;
    end else if (issue) begin
      k   <= k + CW'(1);
      pos <= (pos == LAST_POS) ? '0 : pos + AW'(1);
    end
  end

  fir16_ram #(
    .WIDTH (SW),
    .DEPTH (fir16_pkg::MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(item_index)),
    .wdata (item_value),
    .raddr (k[AW-1:0]),
    .rdata (coef_q)
  );

  fir16_ram #(
    .WIDTH (SW),
    .DEPTH (fir16_pkg::MAX_TAPS)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (newest_dec),
    .wdata (item_value),
    .raddr (pos),
    .rdata (dly_q)
  );

  // MAC pipeline valids; history older than the fill count reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= issue;
      prod_valid <= rd_valid;
    end
  end

  // product and accumulator (wraps at 32 bits)
  always_ff @(posedge clk) begin
    rd_zero <= k >= fill;
    prod    <= rd_zero ? '0 : XW'(coef_q * dly_q);
    if (dly_we) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

  assign shifted = acc >>> output_shift;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_sample <= shifted[SW-1:0];
    end
  end

  // checks
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!rd_valid && !prod_valid))
    else $error("MAC pipeline busy while accepting an item");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count past delay line length");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fir16_pkg::ST_MAC) |-> (k < n_eff))
    else $error("tap walk past tap count");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == fir16_pkg::ACT_LOAD) |=> !$rose(out_valid))
    else $error("result raised for a coefficient load");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (state == fir16_pkg::ST_DONE && (!out_valid || out_ready))
      |=> (out_valid && in_ready))
    else $error("finished sum not presented");

endmodule

### test/testbench.sv
// testbench: self-checking bench for fir_filter_16bit (direct-form 16-bit FIR).
// Depends on fir16_pkg and the filter RTL. A local predictor of the filter
// works out the expected output; results arrive over a valid/ready channel.
`timescale 1ns / 100ps

module testbench;

  // Coefficients written up front; no tap count used here goes past it
  localparam int COEF_SPAN = 160;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Block ports
  logic                                  in_valid  = 1'b0;
  logic                                  in_ready;
  logic                                  action    = fir16_pkg::ACT_SAMPLE;
  logic [fir16_pkg::INDEX_W-1:0]         tap_index = '0;
  logic signed [fir16_pkg::SAMPLE_W-1:0] value     = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [fir16_pkg::SAMPLE_W-1:0] filtered_sample;
  logic                                  psel      = 1'b0;
  logic                                  penable   = 1'b0;
  logic                                  pwrite    = 1'b0;
  logic [fir16_pkg::APB_ADDR_W-1:0]      paddr     = '0;
  logic [fir16_pkg::APB_DATA_W-1:0]      pwdata    = '0;
  logic [fir16_pkg::APB_DATA_W-1:0]      prdata;
  logic                                  pready;

  fir_filter_16bit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .tap_index(tap_index),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered_sample(filtered_sample),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Filter shadow state: sample history, coefficients, register copies
  logic signed [fir16_pkg::SAMPLE_W-1:0] history     [fir16_pkg::MAX_TAPS];
  logic signed [fir16_pkg::SAMPLE_W-1:0] coef_shadow [fir16_pkg::MAX_TAPS];
  int unsigned                           newest;
  logic [fir16_pkg::TAPS_W-1:0]          taps_cfg;
  logic [fir16_pkg::SHIFT_W-1:0]         shift_cfg;

  logic signed [fir16_pkg::SAMPLE_W-1:0] pending_outputs[$];

  // Idle rates in percent
  int send_idle_pct = 11;
  int recv_idle_pct = 50;

  int fail_count  = 0;
  int n_samples   = 0;
  int n_loads     = 0;
  int n_results   = 0;
  int n_settings  = 0;

  // Push one sample into the history and form the expected filter output
  function automatic logic signed [fir16_pkg::SAMPLE_W-1:0] predict_filtered(
      input logic signed [fir16_pkg::SAMPLE_W-1:0] smp);
    int unsigned        n;
    int unsigned        pos;
    int unsigned        k;
    logic signed [31:0] acc;
    newest = (newest == 0) ? fir16_pkg::MAX_TAPS - 1 : newest - 1;
    history[newest] = smp;
    // out-of-range tap counts clamp to 1 .. MAX_TAPS
    n = 32'(taps_cfg);
    if (n < 1) n = 1;
    if (n > fir16_pkg::MAX_TAPS) n = fir16_pkg::MAX_TAPS;
    acc = '0;
    pos = newest;
    for (k = 0; k < n; k++) begin
      acc = acc + 32'(history[pos]) * 32'(coef_shadow[k]);
      pos = (pos == fir16_pkg::MAX_TAPS - 1) ? 0 : pos + 1;
    end
    acc = acc >>> shift_cfg;
    return acc[fir16_pkg::SAMPLE_W-1:0];
  endfunction

  // Full-range value with extra weight on the extremes
  function automatic logic signed [fir16_pkg::SAMPLE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd0;
      default: return fir16_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result against the oldest expectation
  always @(posedge clk) begin : result_check
    logic signed [fir16_pkg::SAMPLE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_outputs.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d: got %0d with nothing pending", n_results, filtered_sample);
      end else begin
        want = pending_outputs.pop_front();
        if (filtered_sample !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: filtered_sample expected %0d, got %0d",
                     n_results, want, filtered_sample);
        end
      end
    end
  end

  // Send one item; returns right after the edge that accepts it
  task automatic send_item(input fir16_pkg::action_t act,
                           input logic [fir16_pkg::INDEX_W-1:0] idx,
                           input logic signed [fir16_pkg::SAMPLE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    tap_index <= idx;
    value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == fir16_pkg::ACT_SAMPLE) begin
      pending_outputs.push_back(predict_filtered(val));
      n_samples++;
    end else begin
      coef_shadow[idx] = val;
      n_loads++;
    end
  endtask

  // Let every result drain; the extra cycles cover a load still in progress
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready, then back to idle
  task automatic reg_write(input fir16_pkg::reg_index_t idx,
                           input logic [fir16_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      fir16_pkg::REG_TAPS:  taps_cfg  = data[fir16_pkg::TAPS_W-1:0];
      fir16_pkg::REG_SHIFT: shift_cfg = data[fir16_pkg::SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // APB read: setup cycle, then access until pready, then back to idle
  task automatic reg_read(input fir16_pkg::reg_index_t idx,
                          output logic [fir16_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int taps, input int shift);
    wait_idle();
    reg_write(fir16_pkg::REG_TAPS, taps);
    reg_write(fir16_pkg::REG_SHIFT, shift);
    n_settings++;
  endtask

  // Every coefficient in use gets written before any sample reads it
  task automatic test_coefficient_preload();
    int i;
    for (i = 0; i < COEF_SPAN; i++)
      send_item(fir16_pkg::ACT_LOAD, fir16_pkg::INDEX_W'(i), pick_value());
  endtask

  // Registers read back their reset values; reset shift on a cleared history
  task automatic test_reset_settings();
    logic [fir16_pkg::APB_DATA_W-1:0] rd;
    wait_idle();
    reg_read(fir16_pkg::REG_TAPS, rd);
    if (rd !== fir16_pkg::APB_DATA_W'(fir16_pkg::TAPS_RESET)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("taps_in_use after reset: expected %0d, got %0d",
                 fir16_pkg::TAPS_RESET, rd);
    end
    reg_read(fir16_pkg::REG_SHIFT, rd);
    if (rd !== fir16_pkg::APB_DATA_W'(fir16_pkg::SHIFT_RESET)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("output_shift after reset: expected %0d, got %0d",
                 fir16_pkg::SHIFT_RESET, rd);
    end
    // shorter filter, shift left at its reset value
    reg_write(fir16_pkg::REG_TAPS, COEF_SPAN);
    n_settings++;
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sh7fff);
    send_item(fir16_pkg::ACT_SAMPLE, '1, 16'sh8000);
    send_item(fir16_pkg::ACT_SAMPLE, '0, -16'sd1);
  endtask

  // One tap, no shift: products of the extreme values
  task automatic test_single_tap_extremes();
    configure(1, 0);
    send_item(fir16_pkg::ACT_LOAD, '0, 16'sh7fff);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sh7fff);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sh8000);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sd0);
    send_item(fir16_pkg::ACT_SAMPLE, '0, -16'sd1);
    send_item(fir16_pkg::ACT_LOAD, '0, 16'sh8000);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sh8000);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sh7fff);
  endtask

  // Zero taps act as one
  task automatic test_tap_count_clamp();
    configure(0, 31);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sh8000);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sd1);
  endtask

  // Coefficient changes between samples, tap count changed on live history
  task automatic test_reload_between_samples();
    configure(4, 8);
    send_item(fir16_pkg::ACT_LOAD, 10'd3, 16'sh7fff);
    send_item(fir16_pkg::ACT_SAMPLE, '0, 16'sd1000);
    send_item(fir16_pkg::ACT_LOAD, 10'd1023, -16'sd1);
    send_item(fir16_pkg::ACT_LOAD, '0, 16'sh8000);
    send_item(fir16_pkg::ACT_SAMPLE, '0, -16'sd1);
  endtask

  // Random mix of samples and loads over many settings and idle patterns
  task automatic test_random_traffic();
    int seg;
    int taps;
    int count;
    int k;
    for (seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 11;
      end
      if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      count = 34;
      // longest filter the preloaded coefficients allow
      if (seg == 3 || seg == 9) begin
        taps = COEF_SPAN;
      end else if (seg == 6) begin
        taps = 0;
      end else if ($urandom_range(3) == 0) begin
        taps = $urandom_range(128, 13);
      end else begin
        taps = $urandom_range(12, 1);
      end
      configure(taps, $urandom_range(31));
      for (k = 0; k < count; k++) begin
        if ($urandom_range(99) < 15)
          send_item(fir16_pkg::ACT_LOAD,
                    fir16_pkg::INDEX_W'($urandom_range(fir16_pkg::MAX_TAPS - 1)),
                    pick_value());
        else
          send_item(fir16_pkg::ACT_SAMPLE, fir16_pkg::INDEX_W'($urandom), pick_value());
      end
    end
  endtask

  // Test sequence
  initial begin
    for (int i = 0; i < fir16_pkg::MAX_TAPS; i++) begin
      history[i]     = '0;
      coef_shadow[i] = '0;
    end
    newest    = 0;
    taps_cfg  = fir16_pkg::TAPS_RESET;
    shift_cfg = fir16_pkg::SHIFT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_coefficient_preload();
    test_reset_settings();
    test_single_tap_extremes();
    test_tap_count_clamp();
    test_reload_between_samples();
    test_random_traffic();

    // drain, then keep watching for stray results
    wait_idle();
    repeat (fir16_pkg::MAX_TAPS + 16) @(posedge clk);

    $display("covered %0d samples and %0d coefficient loads over %0d register settings",
             n_samples, n_loads, n_settings);
    $display("checked %0d filtered results, %0d failures", n_results, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule
